// ===== hw/rtl/tcbkt_pkg.sv =====
// Shared types, constants and the micro-op table of the TCB key tangent generator.
package tcbkt_pkg;

  // Interpolation codes of a key.
  localparam logic [1:0] KIND_CONST  = 2'd0;
  localparam logic [1:0] KIND_LINEAR = 2'd1;
  localparam logic [1:0] KIND_CUBIC  = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  // Unity in Q2.14, widened to the factor width.
  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

  // Rounding biases for the coefficient (Q42 to Q24) and sum (Q40 to Q16.16) steps.
  localparam logic signed [50:0] RND_K   = 51'sd262144;
  localparam logic signed [63:0] RND_SUM = 64'sd8388608;

  // Index of the last micro-op of a middle cubic key.
  localparam logic [4:0] LAST_OP = 5'd21;

  // Saturation bounds for the 32-bit results.
  localparam logic signed [39:0] SAT_MAX = 40'sh007FFFFFFF;
  localparam logic signed [39:0] SAT_MIN = -40'sh0080000000;

  // Key window handed to the tangent engine.
  typedef struct packed {
    logic signed [31:0] prev_time;
    logic signed [31:0] prev_value;
    logic signed [31:0] cur_time;
    logic signed [31:0] cur_value;
    logic signed [31:0] next_time;
    logic signed [31:0] next_value;
    logic signed [15:0] tension;
    logic signed [15:0] continuity;
    logic signed [15:0] bias;
    logic [1:0]         interp;
    logic               first;
    logic               last;
  } tcbkt_win_t;

  // One finished result.
  typedef struct packed {
    logic signed [31:0] tangent_in_x;
    logic signed [31:0] tangent_in_y;
    logic signed [31:0] tangent_out_x;
    logic signed [31:0] tangent_out_y;
    logic [1:0]         interp_code;
    logic               negative_time_error;
    logic               final_key;
  } tcbkt_res_t;

  // Multiplier operand A sources.
  typedef enum logic [2:0] {
    A_SEL_A, A_SEL_ABCP, A_SEL_ABCM, A_SEL_K1, A_SEL_K2, A_SEL_K3, A_SEL_K4
  } tcbkt_asel_t;

  // Multiplier operand B sources; _H is the signed upper part of a
  // difference, _L its unsigned lower 16 bits.
  typedef enum logic [3:0] {
    B_SEL_CP, B_SEL_CM, B_SEL_BP, B_SEL_BM,
    B_SEL_DNX_H, B_SEL_DNX_L, B_SEL_DNY_H, B_SEL_DNY_L,
    B_SEL_DPX_H, B_SEL_DPX_L, B_SEL_DPY_H, B_SEL_DPY_L
  } tcbkt_bsel_t;

  // What is done with a product when it comes back.
  typedef enum logic [3:0] {
    P_NONE, P_ABCP, P_ABCM, P_K1, P_K2, P_K3, P_K4,
    P_ACC_INIT, P_ACC_ADD, P_FIN_TIX, P_FIN_TIY, P_FIN_TOX, P_FIN_TOY
  } tcbkt_proc_t;

  typedef struct packed {
    tcbkt_asel_t a_sel;
    tcbkt_bsel_t b_sel;
    tcbkt_proc_t proc;
    logic        hi;
  } tcbkt_uop_t;

  // Micro-op program of a middle cubic key. The first six ops build the
  // four coefficients, the rest accumulate coefficient times difference,
  // each difference split into an upper and a lower half.
  function automatic tcbkt_uop_t tcbkt_uop(input logic [4:0] idx);
    tcbkt_uop_t u;
    u = '{a_sel: A_SEL_A, b_sel: B_SEL_CP, proc: P_NONE, hi: 1'b0};
    case (idx)
      5'd0:  u = '{a_sel: A_SEL_A,    b_sel: B_SEL_CP,    proc: P_ABCP,     hi: 1'b0};
      5'd1:  u = '{a_sel: A_SEL_A,    b_sel: B_SEL_CM,    proc: P_ABCM,     hi: 1'b0};
      5'd2:  u = '{a_sel: A_SEL_ABCP, b_sel: B_SEL_BM,    proc: P_K1,       hi: 1'b0};
      5'd3:  u = '{a_sel: A_SEL_ABCM, b_sel: B_SEL_BP,    proc: P_K2,       hi: 1'b0};
      5'd4:  u = '{a_sel: A_SEL_ABCM, b_sel: B_SEL_BM,    proc: P_K3,       hi: 1'b0};
      5'd5:  u = '{a_sel: A_SEL_ABCP, b_sel: B_SEL_BP,    proc: P_K4,       hi: 1'b0};
      5'd6:  u = '{a_sel: A_SEL_K1,   b_sel: B_SEL_DNX_H, proc: P_ACC_INIT, hi: 1'b1};
      5'd7:  u = '{a_sel: A_SEL_K1,   b_sel: B_SEL_DNX_L, proc: P_ACC_ADD,  hi: 1'b0};
      5'd8:  u = '{a_sel: A_SEL_K2,   b_sel: B_SEL_DPX_H, proc: P_ACC_ADD,  hi: 1'b1};
      5'd9:  u = '{a_sel: A_SEL_K2,   b_sel: B_SEL_DPX_L, proc: P_FIN_TIX,  hi: 1'b0};
      5'd10: u = '{a_sel: A_SEL_K1,   b_sel: B_SEL_DNY_H, proc: P_ACC_INIT, hi: 1'b1};
      5'd11: u = '{a_sel: A_SEL_K1,   b_sel: B_SEL_DNY_L, proc: P_ACC_ADD,  hi: 1'b0};
      5'd12: u = '{a_sel: A_SEL_K2,   b_sel: B_SEL_DPY_H, proc: P_ACC_ADD,  hi: 1'b1};
      5'd13: u = '{a_sel: A_SEL_K2,   b_sel: B_SEL_DPY_L, proc: P_FIN_TIY,  hi: 1'b0};
      5'd14: u = '{a_sel: A_SEL_K3,   b_sel: B_SEL_DNX_H, proc: P_ACC_INIT, hi: 1'b1};
      5'd15: u = '{a_sel: A_SEL_K3,   b_sel: B_SEL_DNX_L, proc: P_ACC_ADD,  hi: 1'b0};
      5'd16: u = '{a_sel: A_SEL_K4,   b_sel: B_SEL_DPX_H, proc: P_ACC_ADD,  hi: 1'b1};
      5'd17: u = '{a_sel: A_SEL_K4,   b_sel: B_SEL_DPX_L, proc: P_FIN_TOX,  hi: 1'b0};
      5'd18: u = '{a_sel: A_SEL_K3,   b_sel: B_SEL_DNY_H, proc: P_ACC_INIT, hi: 1'b1};
      5'd19: u = '{a_sel: A_SEL_K3,   b_sel: B_SEL_DNY_L, proc: P_ACC_ADD,  hi: 1'b0};
      5'd20: u = '{a_sel: A_SEL_K4,   b_sel: B_SEL_DPY_H, proc: P_ACC_ADD,  hi: 1'b1};
      5'd21: u = '{a_sel: A_SEL_K4,   b_sel: B_SEL_DPY_L, proc: P_FIN_TOY,  hi: 1'b0};
      default: u = '{a_sel: A_SEL_A,  b_sel: B_SEL_CP,    proc: P_NONE,     hi: 1'b0};
    endcase
    return u;
  endfunction

  // Clamp a 40-bit signed value to the 32-bit signed range.
  function automatic logic signed [31:0] tcbkt_sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tcb_key_tangents.sv =====
// Top level of the Kochanek-Bartels (TCB) key tangent generator.
//
// Keys of one animation curve enter in order on the s_axis channel; each
// transaction carries time, value, tension, continuity and bias in tdata,
// the interpolation kind in tuser and the end-of-curve mark in tlast.
// The block keeps a window of previous, current and next key, so the result
// for a key leaves on m_axis when the following key arrives; the key that
// carries tlast yields the held key's result and then its own, with m_axis
// tlast set on that closing result. Cubic middle keys get TCB tangents, the
// first and last cubic keys a chord, all other keys zero tangents.
// A middle cubic key is computed by one shared 33 x 17 multiplier under a
// 22-op micro-program (six ops for the four coefficients, then sixteen
// partial products). The block takes the next key only once the results
// that the last key released, and for the closing key its own, have moved
// to the output register.
// s_axis_tready is high only while the block waits for a key. A finished
// result sits in the m_axis output register; while the receiver stalls the
// engine holds the next result and the sequencer waits for it to drain.
// Reset empties the window and the output register; no clearing pass.
module tcb_key_tangents (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // [31:0] key_time, [63:32] key_value, [79:64] tension,
  // [95:80] continuity, [111:96] bias
  input  logic [111:0]   s_axis_tdata,
  // [1:0] interp_kind
  input  logic [1:0]     s_axis_tuser,
  input  logic           s_axis_tlast,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // [31:0] tangent_in_x, [63:32] tangent_in_y, [95:64] tangent_out_x,
  // [127:96] tangent_out_y
  output logic [127:0]   m_axis_tdata,
  // [1:0] interp_code, [2] negative_time_error
  output logic [2:0]     m_axis_tuser,
  output logic           m_axis_tlast
);
  import tcbkt_pkg::*;

  typedef enum logic [5:0] {
    T_IDLE   = 6'b000001,
    T_START1 = 6'b000010,
    T_WAIT1  = 6'b000100,
    T_SHIFT  = 6'b001000,
    T_START2 = 6'b010000,
    T_WAIT2  = 6'b100000
  } top_state_t;

  top_state_t state, state_next;

  // Incoming key.
  logic signed [31:0] in_time, in_value;
  logic signed [15:0] in_tension, in_cont, in_bias;
  logic [1:0]         in_kind;
  logic               in_eoc;

  // Key window.
  logic signed [31:0] prev_time, prev_value, cur_time, cur_value;
  logic signed [15:0] cur_tension, cur_cont, cur_bias;
  logic [1:0]         cur_interp;
  logic               cur_pending, cur_is_first;

  tcbkt_win_t win;
  tcbkt_res_t res;
  logic       eng_start, eng_done, ack, s_accept;

  assign s_axis_tready = (state == T_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign eng_start     = (state == T_START1) || (state == T_START2);
  // A finished result moves to the output register once that register is free.
  assign ack           = eng_done && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    win.prev_time  = prev_time;
    win.prev_value = prev_value;
    win.cur_time   = cur_time;
    win.cur_value  = cur_value;
    win.next_time  = in_time;
    win.next_value = in_value;
    win.tension    = cur_tension;
    win.continuity = cur_cont;
    win.bias       = cur_bias;
    win.interp     = cur_interp;
    win.first      = cur_is_first;
    win.last       = (state == T_START2) || (state == T_WAIT2);
  end

  tcbkt_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .win   (win),
    .ack   (ack),
    .done  (eng_done),
    .res   (res)
  );

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (s_accept) begin
          state_next = cur_pending ? T_START1 : T_SHIFT;
        end
      end
      T_START1: state_next = T_WAIT1;
      T_WAIT1: begin
        if (ack) begin
          state_next = T_SHIFT;
        end
      end
      T_SHIFT: state_next = in_eoc ? T_START2 : T_IDLE;
      T_START2: state_next = T_WAIT2;
      T_WAIT2: begin
        if (ack) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      cur_pending  <= 1'b0;
      cur_is_first <= 1'b0;
    end else begin
      state <= state_next;
      if (state == T_SHIFT) begin
        cur_is_first <= !cur_pending;
        cur_pending  <= !in_eoc;
      end
    end
  end

  // Key capture and window shift.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_time    <= s_axis_tdata[31:0];
      in_value   <= s_axis_tdata[63:32];
      in_tension <= s_axis_tdata[79:64];
      in_cont    <= s_axis_tdata[95:80];
      in_bias    <= s_axis_tdata[111:96];
      in_kind    <= s_axis_tuser;
      in_eoc     <= s_axis_tlast;
    end
    if (state == T_SHIFT) begin
      prev_time   <= cur_time;
      prev_value  <= cur_value;
      cur_time    <= in_time;
      cur_value   <= in_value;
      cur_tension <= in_tension;
      cur_cont    <= in_cont;
      cur_bias    <= in_bias;
      cur_interp  <= in_kind;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ack) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (ack) begin
      m_axis_tdata <= {res.tangent_out_y, res.tangent_out_x,
                       res.tangent_in_y, res.tangent_in_x};
      m_axis_tuser <= {res.negative_time_error, res.interp_code};
      m_axis_tlast <= res.final_key;
    end
  end

  // While waiting for a key, the engine must not still hold a result.
  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !eng_done)
    else $error("engine holds a result while the block is ready");

  // The error flag is only raised on cubic keys.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == KIND_CUBIC))
    else $error("negative time error on a non-cubic key");

  // Non-cubic keys carry zero tangents.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser[1:0] != KIND_CUBIC)) |-> (m_axis_tdata == '0))
    else $error("non-cubic key with nonzero tangents");

  // The closing key leaves no key held in the window.
  assert property (@(posedge clk) disable iff (rst)
    ((state == T_SHIFT) && in_eoc) |=> !cur_pending)
    else $error("key still pending after end of curve");

endmodule

// ===== hw/rtl/tcbkt_mul.sv =====
// Shared signed 33 x 17 multiplier with a registered product and tag.
module tcbkt_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               issue,
  input  logic signed [32:0] op_a,
  input  logic signed [16:0] op_b,
  input  logic [4:0]         tag,
  output logic               prod_valid,
  output logic signed [49:0] prod,
  output logic [4:0]         prod_tag
);
  import tcbkt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= issue;
    end
    prod     <= op_a * op_b;
    prod_tag <= tag;
  end

endmodule

// ===== hw/rtl/tcbkt_engine.sv =====
// Tangent engine: computes one key's result, sequencing the shared multiplier.
module tcbkt_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tcbkt_pkg::tcbkt_win_t win,
  input  logic                  ack,
  output logic                  done,
  output tcbkt_pkg::tcbkt_res_t res
);
  import tcbkt_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE  = 4'b0001,
    E_ISSUE = 4'b0010,
    E_DRAIN = 4'b0100,
    E_DONE  = 4'b1000
  } eng_state_t;

  eng_state_t state, state_next;
  logic [4:0] step;

  // Factors and differences held for the whole run.
  logic signed [16:0] fa, fcp, fcm, fbp, fbm;
  logic signed [32:0] dnx, dny, dpx, dpy;
  logic signed [32:0] abcp, abcm;
  logic signed [28:0] k1, k2, k3, k4;
  logic signed [63:0] acc;

  // Result registers.
  logic signed [31:0] tix, tiy, tox, toy;
  logic [1:0]         code_r;
  logic               err_in, err_out, final_r;

  // Start-time decode.
  logic [1:0]         code;
  logic               cubic, middle;
  logic signed [32:0] dnx_w, dny_w, dpx_w, dpy_w;

  // Multiplier interface.
  logic               mul_issue;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic               prod_valid;
  logic signed [49:0] prod;
  logic [4:0]         prod_tag;
  tcbkt_uop_t         uop_i, uop_p;

  // Product post-processing.
  logic signed [63:0] term, sum;
  logic signed [50:0] ksum;
  logic signed [28:0] kval;
  logic signed [39:0] val;

  tcbkt_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .issue      (mul_issue),
    .op_a       (mul_a),
    .op_b       (mul_b),
    .tag        (step),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_tag   (prod_tag)
  );

  always_comb begin
    code   = (win.interp == KIND_RSVD) ? KIND_CONST : win.interp;
    cubic  = (code == KIND_CUBIC);
    middle = cubic && !win.first && !win.last;
    dnx_w  = 33'(win.next_time) - 33'(win.cur_time);
    dny_w  = 33'(win.next_value) - 33'(win.cur_value);
    dpx_w  = 33'(win.cur_time) - 33'(win.prev_time);
    dpy_w  = 33'(win.cur_value) - 33'(win.prev_value);
  end

  // Operand selection for the op being issued.
  always_comb begin
    uop_i     = tcbkt_uop(step);
    mul_issue = (state == E_ISSUE);
    case (uop_i.a_sel)
      A_SEL_A:    mul_a = 33'(fa);
      A_SEL_ABCP: mul_a = abcp;
      A_SEL_ABCM: mul_a = abcm;
      A_SEL_K1:   mul_a = 33'(k1);
      A_SEL_K2:   mul_a = 33'(k2);
      A_SEL_K3:   mul_a = 33'(k3);
      A_SEL_K4:   mul_a = 33'(k4);
      default:    mul_a = '0;
    endcase
    case (uop_i.b_sel)
      B_SEL_CP:    mul_b = fcp;
      B_SEL_CM:    mul_b = fcm;
      B_SEL_BP:    mul_b = fbp;
      B_SEL_BM:    mul_b = fbm;
      B_SEL_DNX_H: mul_b = dnx[32:16];
      B_SEL_DNX_L: mul_b = {1'b0, dnx[15:0]};
      B_SEL_DNY_H: mul_b = dny[32:16];
      B_SEL_DNY_L: mul_b = {1'b0, dny[15:0]};
      B_SEL_DPX_H: mul_b = dpx[32:16];
      B_SEL_DPX_L: mul_b = {1'b0, dpx[15:0]};
      B_SEL_DPY_H: mul_b = dpy[32:16];
      B_SEL_DPY_L: mul_b = {1'b0, dpy[15:0]};
      default:     mul_b = '0;
    endcase
  end

  // Returning product: coefficient rounding or accumulation.
  always_comb begin
    uop_p = tcbkt_uop(prod_tag);
    term  = uop_p.hi ? (64'(prod) <<< 16) : 64'(prod);
    sum   = ((uop_p.proc == P_ACC_INIT) ? RND_SUM : acc) + term;
    val   = sum[63:24];
    ksum  = 51'(prod) + RND_K;
    kval  = ksum[47:19];
  end

  always_comb begin
    state_next = state;
    case (state)
      E_IDLE: begin
        if (start) begin
          state_next = middle ? E_ISSUE : E_DONE;
        end
      end
      E_ISSUE: begin
        if (step == LAST_OP) begin
          state_next = E_DRAIN;
        end
      end
      E_DRAIN: state_next = E_DONE;
      E_DONE: begin
        if (ack) begin
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_ISSUE) begin
      step <= step + 5'd1;
    end else begin
      step <= '0;
    end

    if (state == E_IDLE && start) begin
      tix     <= '0;
      tiy     <= '0;
      tox     <= '0;
      toy     <= '0;
      err_in  <= 1'b0;
      err_out <= 1'b0;
      code_r  <= code;
      final_r <= win.last;
      fa      <= ONE_Q14 - 17'(win.tension);
      fcp     <= ONE_Q14 + 17'(win.continuity);
      fcm     <= ONE_Q14 - 17'(win.continuity);
      fbp     <= ONE_Q14 + 17'(win.bias);
      fbm     <= ONE_Q14 - 17'(win.bias);
      dnx     <= dnx_w;
      dny     <= dny_w;
      dpx     <= dpx_w;
      dpy     <= dpy_w;
      // End keys of a cubic run get a plain chord; a lone key gets nothing.
      if (cubic && win.first && !win.last) begin
        tox     <= tcbkt_sat32(40'(dnx_w));
        toy     <= tcbkt_sat32(40'(dny_w));
        err_out <= dnx_w[32];
      end else if (cubic && win.last && !win.first) begin
        tix    <= tcbkt_sat32(40'(dpx_w));
        tiy    <= tcbkt_sat32(40'(dpy_w));
        err_in <= dpx_w[32];
      end
    end else if (prod_valid) begin
      case (uop_p.proc)
        P_ABCP:     abcp <= prod[32:0];
        P_ABCM:     abcm <= prod[32:0];
        P_K1:       k1 <= kval;
        P_K2:       k2 <= kval;
        P_K3:       k3 <= kval;
        P_K4:       k4 <= kval;
        P_ACC_INIT: acc <= sum;
        P_ACC_ADD:  acc <= sum;
        P_FIN_TIX: begin
          tix    <= tcbkt_sat32(val);
          err_in <= val[39];
        end
        P_FIN_TIY:  tiy <= tcbkt_sat32(val);
        P_FIN_TOX: begin
          tox     <= tcbkt_sat32(val);
          err_out <= val[39];
        end
        P_FIN_TOY:  toy <= tcbkt_sat32(val);
        default:    acc <= acc;
      endcase
    end
  end

  always_comb begin
    done                    = (state == E_DONE);
    res.tangent_in_x        = tix;
    res.tangent_in_y        = tiy;
    res.tangent_out_x       = tox;
    res.tangent_out_y       = toy;
    res.interp_code         = code_r;
    res.negative_time_error = err_in | err_out;
    res.final_key           = final_r;
  end

endmodule
